// ===== hw/rtl/pbst_pkg.sv =====
// ----------------------------------------------------------------------------
// pbst_pkg
// Shared types, constants and helpers of the pulse-width bit transmitter.
// ----------------------------------------------------------------------------
package pbst_pkg;

   // Bit FIFO geometry (depth is a power of two, pointers wrap naturally)
   localparam int FIFO_BITS = 1024;
   localparam int PTR_W     = $clog2(FIFO_BITS);
   localparam int CNT_W     = PTR_W + 1;

   // Tick counter and timing register width
   localparam int TICK_W    = 16;

   // Register file
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TICKS  = 3'd0,
      CSR_BIT_PERIOD   = 3'd1,
      CSR_ZERO_ON      = 3'd2,
      CSR_ONE_ON       = 3'd3,
      CSR_END_GAP      = 3'd4
   } csr_index_type;

   localparam logic [TICK_W-1:0] START_TICKS_RST = TICK_W'(170);
   localparam logic [TICK_W-1:0] BIT_PERIOD_RST  = TICK_W'(40);
   localparam logic [TICK_W-1:0] ZERO_ON_RST     = TICK_W'(33);
   localparam logic [TICK_W-1:0] ONE_ON_RST      = TICK_W'(20);
   localparam logic [TICK_W-1:0] END_GAP_RST     = TICK_W'(100);

   typedef struct packed {
      logic [TICK_W-1:0] start_ticks;
      logic [TICK_W-1:0] bit_period_ticks;
      logic [TICK_W-1:0] zero_on_ticks;
      logic [TICK_W-1:0] one_on_ticks;
      logic [TICK_W-1:0] end_gap_ticks;
   } cfg_type;

   // Input command codes
   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_SEND = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   // One classified item as it travels from the front to the engine
   typedef struct packed {
      cmd_type kind;
      logic    bit_value;
      logic    end_of_msg;
   } item_type;

   // Transmit sequence phases
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_START   = 3'd1,
      PH_GAP     = 3'd2,
      PH_PULSE   = 3'd3,
      PH_ENDWAIT = 3'd4
   } phase_type;

   // A zero duration is timed as one tick
   function automatic logic [TICK_W-1:0] load_ticks(input logic [TICK_W-1:0] d);
      logic [TICK_W-1:0] r;
      r = (d == '0) ? TICK_W'(1) : d;
      return r;
   endfunction

endpackage

// ===== hw/rtl/pwm_bit_serial_transmitter.sv =====
// ----------------------------------------------------------------------------
// pwm_bit_serial_transmitter
// Pulse-width bit transmitter for a two-level bus line with a bit FIFO.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_cmd, req_bit_value, req_end_of_msg
//   rsp      out        rsp_valid / rsp_stall  rsp_line_active, rsp_pin_level,
//                                              rsp_busy_res, rsp_push_dropped,
//                                              rsp_msg_sent
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// One item per clock sustained while the result side does not stall; each item's
// result passes through the front queue, then the engine's result register.
// The engine updates timer, sequencer and bit FIFO counters in the same cycle;
// the bit store is read ahead of use into a register, with write forwarding.
// Reset clears the queue, sequencer and FIFO pointers; registers return to
// their defaults. A stalled result holds; the two-entry queue keeps taking
// items until it fills.
// ----------------------------------------------------------------------------
module pwm_bit_serial_transmitter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_cmd,
   input  logic                            req_bit_value,
   input  logic                            req_end_of_msg,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_line_active,
   output logic                            rsp_pin_level,
   output logic                            rsp_busy_res,
   output logic                            rsp_push_dropped,
   output logic                            rsp_msg_sent,
   input  logic                            csr_write_enable,
   input  logic [pbst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pbst_pkg::TICK_W-1:0]     csr_write_data
);

   pbst_pkg::cfg_type  cfg_ff;
   logic               q_valid;
   logic               q_pop;
   pbst_pkg::item_type q_item;

   // Timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_ticks      <= pbst_pkg::START_TICKS_RST;
         cfg_ff.bit_period_ticks <= pbst_pkg::BIT_PERIOD_RST;
         cfg_ff.zero_on_ticks    <= pbst_pkg::ZERO_ON_RST;
         cfg_ff.one_on_ticks     <= pbst_pkg::ONE_ON_RST;
         cfg_ff.end_gap_ticks    <= pbst_pkg::END_GAP_RST;
      end else if (csr_write_enable) begin
         unique case (pbst_pkg::csr_index_type'(csr_index))
            pbst_pkg::CSR_START_TICKS: cfg_ff.start_ticks      <= csr_write_data;
            pbst_pkg::CSR_BIT_PERIOD:  cfg_ff.bit_period_ticks <= csr_write_data;
            pbst_pkg::CSR_ZERO_ON:     cfg_ff.zero_on_ticks    <= csr_write_data;
            pbst_pkg::CSR_ONE_ON:      cfg_ff.one_on_ticks     <= csr_write_data;
            pbst_pkg::CSR_END_GAP:     cfg_ff.end_gap_ticks    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   pbst_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_bit_value  (req_bit_value),
      .req_end_of_msg (req_end_of_msg),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   pbst_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_active  (rsp_line_active),
      .rsp_pin_level    (rsp_pin_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_push_dropped (rsp_push_dropped),
      .rsp_msg_sent     (rsp_msg_sent)
   );

endmodule

// ===== hw/rtl/pbst_front.sv =====
// ----------------------------------------------------------------------------
// pbst_front
// Accepts items, classifies the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pbst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic              req_bit_value,
   input  logic              req_end_of_msg,
   output logic              q_valid,
   output pbst_pkg::item_type q_item,
   input  logic              q_pop
);

   pbst_pkg::item_type q_mem_ff [2];
   logic               wr_sel_ff, wr_sel_in;
   logic               rd_sel_ff, rd_sel_in;
   logic [1:0]         count_ff, count_in;
   logic               push;
   pbst_pkg::item_type new_item;

   // Classify the incoming command
   always_comb begin
      new_item.kind       = pbst_pkg::cmd_type'(req_cmd);
      new_item.bit_value  = req_bit_value;
      new_item.end_of_msg = req_end_of_msg;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_sel_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_sel_in = push  ? ~wr_sel_ff : wr_sel_ff;
      rd_sel_in = q_pop ? ~rd_sel_ff : rd_sel_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_sel_ff <= wr_sel_in;
         rd_sel_ff <= rd_sel_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued payload
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_sel_ff] <= new_item;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("front queue overfilled");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty front queue");

endmodule

// ===== hw/rtl/pbst_engine.sv =====
// ----------------------------------------------------------------------------
// pbst_engine
// Bit FIFO, tick timer and transmit sequencer; one item per cycle into a
// registered result stage while that stage is not stalled.
// ----------------------------------------------------------------------------
module pbst_engine (
   input  logic               clock,
   input  logic               reset,
   input  pbst_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  pbst_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_line_active,
   output logic               rsp_pin_level,
   output logic               rsp_busy_res,
   output logic               rsp_push_dropped,
   output logic               rsp_msg_sent
);

   localparam logic [pbst_pkg::CNT_W-1:0] FIFO_FULL = pbst_pkg::CNT_W'(pbst_pkg::FIFO_BITS);

   // Bit store: bit 0 value, bit 1 end mark
   logic [1:0] bit_mem [pbst_pkg::FIFO_BITS];
   logic [1:0] rd_data_ff;

   pbst_pkg::phase_type        phase_ff, phase_in;
   logic [pbst_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [pbst_pkg::PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pbst_pkg::PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pbst_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic [pbst_pkg::CNT_W-1:0]  whole_ff, whole_in;
   logic [1:0]                  cur_ff, cur_in;

   logic                        mem_we;
   logic [1:0]                  mem_wdata;
   logic                        dropped, sent;
   logic                        active, busy;
   logic [pbst_pkg::TICK_W-1:0] on_ticks;

   logic rsp_valid_ff;
   logic line_active_ff, busy_ff, dropped_ff, sent_ff;

   // Take an item whenever the result stage is free or draining
   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign mem_wdata = {q_item.end_of_msg, q_item.bit_value};
   assign on_ticks  = cur_ff[0] ? cfg.one_on_ticks : cfg.zero_on_ticks;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in  = fill_ff;
      whole_in = whole_ff;
      cur_in   = cur_ff;
      mem_we   = 1'b0;
      dropped  = 1'b0;
      sent     = 1'b0;
      if (q_pop) begin
         unique case (q_item.kind)
            pbst_pkg::CMD_TICK: begin
               if (phase_ff != pbst_pkg::PH_IDLE) begin
                  if (tick_ff > pbst_pkg::TICK_W'(1)) begin
                     tick_in = tick_ff - pbst_pkg::TICK_W'(1);
                  end else begin
                     // Timer expired: advance the sequence
                     unique case (phase_ff)
                        pbst_pkg::PH_START: begin
                           tick_in  = pbst_pkg::load_ticks(cfg.zero_on_ticks);
                           phase_in = pbst_pkg::PH_GAP;
                        end
                        pbst_pkg::PH_GAP: begin
                           cur_in   = rd_data_ff;
                           tick_in  = pbst_pkg::load_ticks(rd_data_ff[0] ?
                                         cfg.one_on_ticks : cfg.zero_on_ticks);
                           phase_in = pbst_pkg::PH_PULSE;
                        end
                        pbst_pkg::PH_PULSE: begin
                           if (fill_ff != '0) begin
                              rd_ptr_in = rd_ptr_ff + pbst_pkg::PTR_W'(1);
                              fill_in   = fill_ff - pbst_pkg::CNT_W'(1);
                           end
                           if (cur_ff[1]) begin
                              if (whole_ff != '0) begin
                                 whole_in = whole_ff - pbst_pkg::CNT_W'(1);
                              end
                              tick_in  = pbst_pkg::load_ticks(cfg.end_gap_ticks);
                              phase_in = pbst_pkg::PH_ENDWAIT;
                              sent     = 1'b1;
                           end else begin
                              // Short remainder is held at one tick
                              tick_in  = (cfg.bit_period_ticks > on_ticks) ?
                                         (cfg.bit_period_ticks - on_ticks) :
                                         pbst_pkg::TICK_W'(1);
                              phase_in = pbst_pkg::PH_GAP;
                           end
                        end
                        pbst_pkg::PH_ENDWAIT: begin
                           if (whole_ff == '0) begin
                              phase_in = pbst_pkg::PH_IDLE;
                           end else begin
                              tick_in  = pbst_pkg::load_ticks(cfg.start_ticks);
                              phase_in = pbst_pkg::PH_START;
                           end
                        end
                        default: begin
                           phase_in = pbst_pkg::PH_IDLE;
                        end
                     endcase
                  end
               end
            end
            pbst_pkg::CMD_PUSH: begin
               if (fill_ff == FIFO_FULL) begin
                  dropped = 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  wr_ptr_in = wr_ptr_ff + pbst_pkg::PTR_W'(1);
                  fill_in   = fill_ff + pbst_pkg::CNT_W'(1);
                  if (q_item.end_of_msg) begin
                     whole_in = whole_ff + pbst_pkg::CNT_W'(1);
                  end
               end
            end
            pbst_pkg::CMD_SEND: begin
               if (phase_ff == pbst_pkg::PH_IDLE && whole_ff != '0) begin
                  tick_in  = pbst_pkg::load_ticks(cfg.start_ticks);
                  phase_in = pbst_pkg::PH_START;
               end
            end
            pbst_pkg::CMD_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Outputs from the phase after this item
   always_comb begin
      active = (phase_in == pbst_pkg::PH_START) || (phase_in == pbst_pkg::PH_PULSE);
      busy   = (phase_in != pbst_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pbst_pkg::PH_IDLE;
         tick_ff   <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
         whole_ff  <= '0;
         cur_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
         whole_ff  <= whole_in;
         cur_ff    <= cur_in;
      end
   end

   // Write the bit store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bit_mem[wr_ptr_ff] <= mem_wdata;
      end
   end

   // Read the head entry ahead of use; forward a same-cycle write
   always_ff @(posedge clock) begin
      if (mem_we && (wr_ptr_ff == rd_ptr_in)) begin
         rd_data_ff <= mem_wdata;
      end else begin
         rd_data_ff <= bit_mem[rd_ptr_in];
      end
   end

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         line_active_ff <= active;
         busy_ff        <= busy;
         dropped_ff     <= dropped;
         sent_ff        <= sent;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_active  = line_active_ff;
   assign rsp_pin_level    = ~line_active_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_push_dropped = dropped_ff;
   assign rsp_msg_sent     = sent_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= FIFO_FULL) && (whole_ff <= fill_ff))
      else $error("bit FIFO counters out of range");

   a_timer_loaded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != pbst_pkg::PH_IDLE) |-> (tick_ff != '0))
      else $error("timer zero while transmitting");

   a_sent_enters_endwait: assert property (@(posedge clock) disable iff (reset)
      sent |=> (phase_ff == pbst_pkg::PH_ENDWAIT))
      else $error("message end without end gap");

endmodule

// ===== tb/pbst_line_checker.sv =====
// ----------------------------------------------------------------------------
// pbst_line_checker
// Watches the request, result and register ports of the pulse-width bit
// transmitter, predicts the line level, busy flag, drop flag and message-done
// flag for every accepted item, and compares each accepted result with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pbst_line_checker
   import pbst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic                 req_bit_value,
   input  logic                 req_end_of_msg,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_line_active,
   input  logic                 rsp_pin_level,
   input  logic                 rsp_busy_res,
   input  logic                 rsp_push_dropped,
   input  logic                 rsp_msg_sent,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_write_data,
   output int                   errors,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic line_active;
      logic pin_level;
      logic busy;
      logic push_dropped;
      logic msg_sent;
   } line_result_type;

   // Shadow of the transmitter: timing registers, sequencer and bit FIFO
   cfg_type           timing;
   phase_type         seq_phase;
   logic [TICK_W-1:0] ticks_left;
   logic [1:0]        fifo_mem [FIFO_BITS];
   logic [PTR_W-1:0]  rd_ptr;
   logic [PTR_W-1:0]  wr_ptr;
   logic [CNT_W-1:0]  fill_cnt;
   logic [CNT_W-1:0]  msg_cnt;
   logic [1:0]        cur_bit;

   line_result_type expected_levels [$];

   // A programmed duration of zero still lasts one tick
   function automatic logic [TICK_W-1:0] timed_ticks(input logic [TICK_W-1:0] d);
      if (d == '0)
         return TICK_W'(1);
      return d;
   endfunction

   // Apply one item to the shadow state and return the levels it leaves behind
   task automatic advance_line(input cmd_type c, input logic bv, input logic eom,
                               output line_result_type r);
      logic [TICK_W-1:0] on_width;
      r = '0;
      case (c)
         CMD_TICK: if (seq_phase != PH_IDLE) begin
            if (ticks_left > TICK_W'(1)) begin
               ticks_left = ticks_left - TICK_W'(1);
            end else begin
               case (seq_phase)
                  PH_START: begin
                     ticks_left = timed_ticks(timing.zero_on_ticks);
                     seq_phase  = PH_GAP;
                  end
                  PH_GAP: begin
                     cur_bit    = fifo_mem[rd_ptr];
                     ticks_left = timed_ticks(cur_bit[0] ? timing.one_on_ticks
                                                         : timing.zero_on_ticks);
                     seq_phase  = PH_PULSE;
                  end
                  PH_PULSE: begin
                     on_width = cur_bit[0] ? timing.one_on_ticks : timing.zero_on_ticks;
                     if (fill_cnt != '0) begin
                        rd_ptr   = rd_ptr + PTR_W'(1);
                        fill_cnt = fill_cnt - CNT_W'(1);
                     end
                     if (cur_bit[1]) begin
                        // last bit of the message: hold the end gap
                        if (msg_cnt != '0)
                           msg_cnt = msg_cnt - CNT_W'(1);
                        ticks_left = timed_ticks(timing.end_gap_ticks);
                        seq_phase  = PH_ENDWAIT;
                        r.msg_sent = 1'b1;
                     end else begin
                        // remainder of the bit period, never under one tick
                        ticks_left = (timing.bit_period_ticks > on_width)
                                     ? timing.bit_period_ticks - on_width : TICK_W'(1);
                        seq_phase  = PH_GAP;
                     end
                  end
                  PH_ENDWAIT: begin
                     if (msg_cnt == '0) begin
                        seq_phase = PH_IDLE;
                     end else begin
                        ticks_left = timed_ticks(timing.start_ticks);
                        seq_phase  = PH_START;
                     end
                  end
                  default: seq_phase = PH_IDLE;
               endcase
            end
         end
         CMD_PUSH: begin
            if (fill_cnt >= CNT_W'(FIFO_BITS)) begin
               r.push_dropped = 1'b1;
            end else begin
               fifo_mem[wr_ptr] = {eom, bv};
               wr_ptr   = wr_ptr + PTR_W'(1);
               fill_cnt = fill_cnt + CNT_W'(1);
               if (eom)
                  msg_cnt = msg_cnt + CNT_W'(1);
            end
         end
         CMD_SEND: begin
            if (seq_phase == PH_IDLE && msg_cnt != '0) begin
               ticks_left = timed_ticks(timing.start_ticks);
               seq_phase  = PH_START;
            end
         end
         default: ;
      endcase
      r.line_active = (seq_phase == PH_START || seq_phase == PH_PULSE);
      r.pin_level   = ~r.line_active;
      r.busy        = (seq_phase != PH_IDLE);
   endtask

   task automatic check_field(input string name, input logic want_b, input logic got_b);
      if (got_b !== want_b) begin
         errors++;
         $display("%0t ns: %s expected %0b, got %0b", $time, name, want_b, got_b);
      end
   endtask

   // Track register writes, predict on accepted items, compare accepted results
   always @(posedge clock) begin
      line_result_type want;
      line_result_type got;
      if (reset) begin
         timing.start_ticks      = START_TICKS_RST;
         timing.bit_period_ticks = BIT_PERIOD_RST;
         timing.zero_on_ticks    = ZERO_ON_RST;
         timing.one_on_ticks     = ONE_ON_RST;
         timing.end_gap_ticks    = END_GAP_RST;
         seq_phase  = PH_IDLE;
         ticks_left = '0;
         rd_ptr     = '0;
         wr_ptr     = '0;
         fill_cnt   = '0;
         msg_cnt    = '0;
         cur_bit    = '0;
         errors     = 0;
         expected_levels.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_START_TICKS: timing.start_ticks      = csr_write_data;
               CSR_BIT_PERIOD:  timing.bit_period_ticks = csr_write_data;
               CSR_ZERO_ON:     timing.zero_on_ticks    = csr_write_data;
               CSR_ONE_ON:      timing.one_on_ticks     = csr_write_data;
               CSR_END_GAP:     timing.end_gap_ticks    = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_line(cmd_type'(req_cmd), req_bit_value, req_end_of_msg, want);
            expected_levels.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_line_active, rsp_pin_level, rsp_busy_res,
                    rsp_push_dropped, rsp_msg_sent};
            if (expected_levels.size() == 0) begin
               errors++;
               $display("%0t ns: result with nothing expected, got %b", $time, got);
            end else begin
               want = expected_levels.pop_front();
               check_field("line_active", want.line_active, got.line_active);
               check_field("pin_level", want.pin_level, got.pin_level);
               check_field("busy_res", want.busy, got.busy);
               check_field("push_dropped", want.push_dropped, got.push_dropped);
               check_field("msg_sent", want.msg_sent, got.msg_sent);
            end
         end
      end
      pending = expected_levels.size();
   end

endmodule

// ===== tb/tb_pwm_bit_serial_transmitter.sv =====
// ----------------------------------------------------------------------------
// tb_pwm_bit_serial_transmitter
// Drives the pulse-width bit transmitter with directed corner cases, then with
// random messages, tick bursts and noise under several timing settings, and
// finally floods the bit FIFO past full. Both channels idle at random; the
// line checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_pwm_bit_serial_transmitter;
   timeunit 1ns;
   timeprecision 1ps;

   import pbst_pkg::*;

   localparam int STUCK_LIMIT  = 2000;
   localparam int SETTLE_TICKS = 4;
   localparam int PHASE_ITEMS  = 135;
   localparam int FLOOD_PUSHES = 1060;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_cmd          = CMD_TICK;
   logic                 req_bit_value    = 1'b0;
   logic                 req_end_of_msg   = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic                 rsp_line_active;
   logic                 rsp_pin_level;
   logic                 rsp_busy_res;
   logic                 rsp_push_dropped;
   logic                 rsp_msg_sent;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_START_TICKS;
   logic [TICK_W-1:0]    csr_write_data   = '0;

   int   errors;
   int   pending;
   int   item_count = 0;
   int   stuck_cycles = 0;
   logic quiet = 1'b0;

   pwm_bit_serial_transmitter uut (.*);

   pbst_line_checker line_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side: stall about one cycle in five unless in a quiet stretch
   always @(negedge clock)
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 19);

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input cmd_type c, input logic bv, input logic eom);
      int gaps;
      gaps = 0;
      if (!quiet)
         while ($urandom_range(0, 99) < 19) gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= c;
      req_bit_value  <= bv;
      req_end_of_msg <= eom;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      item_count++;
   endtask

   task automatic run_ticks(input int n);
      repeat (n) send_item(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic push_message(input int nbits);
      for (int i = 0; i < nbits; i++)
         send_item(CMD_PUSH, 1'($urandom_range(0, 1)), i == nbits - 1);
   endtask

   // Drop valid and wait until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_timing(input logic [TICK_W-1:0] st, input logic [TICK_W-1:0] bp,
                               input logic [TICK_W-1:0] z, input logic [TICK_W-1:0] o,
                               input logic [TICK_W-1:0] eg);
      csr_index_type     regs [5];
      logic [TICK_W-1:0] vals [5];
      regs = '{CSR_START_TICKS, CSR_BIT_PERIOD, CSR_ZERO_ON, CSR_ONE_ON, CSR_END_GAP};
      vals = '{st, bp, z, o, eg};
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= regs[i];
         csr_write_data   <= vals[i];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Mostly complete messages followed by a send and ticks; some noise
   task automatic run_mix(input int budget);
      int target;
      int pick;
      target = item_count + budget;
      while (item_count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            push_message($urandom_range(1, 8));
            send_item(CMD_SEND, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            run_ticks($urandom_range(5, 60));
         end else if (pick < 80) begin
            run_ticks($urandom_range(1, 30));
         end else if (pick < 92) begin
            send_item(cmd_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else if (pick < 96) begin
            // bits with no end mark: they wait for a later message
            repeat ($urandom_range(1, 3))
               send_item(CMD_PUSH, 1'($urandom_range(0, 1)), 1'b0);
         end else begin
            send_item(CMD_SEND, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Idle corners under the reset timing
      send_item(CMD_TICK, 1'b0, 1'b0);
      send_item(CMD_NOP, 1'b1, 1'b1);
      send_item(CMD_SEND, 1'b0, 1'b0);
      send_item(CMD_PUSH, 1'b1, 1'b0);
      send_item(CMD_SEND, 1'b1, 1'b1);
      send_item(CMD_TICK, 1'b1, 1'b1);
      settle();

      // Zero durations and a bit period no longer than either pulse
      write_timing(16'd0, 16'd1, 16'd2, 16'd1, 16'd0);
      send_item(CMD_PUSH, 1'b0, 1'b1);
      send_item(CMD_SEND, 1'b0, 1'b0);
      send_item(CMD_SEND, 1'b1, 1'b0);
      run_ticks(6);
      send_item(CMD_PUSH, 1'b1, 1'b1);
      run_ticks(9);
      settle();

      // Random phases, shortest settings first
      write_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      run_mix(PHASE_ITEMS);
      settle();
      write_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_mix(PHASE_ITEMS);
      settle();
      for (int ph = 0; ph < 4; ph++) begin
         write_timing(TICK_W'($urandom_range(0, 4)), TICK_W'($urandom_range(0, 6)),
                      TICK_W'($urandom_range(0, 4)), TICK_W'($urandom_range(0, 4)),
                      TICK_W'($urandom_range(0, 4)));
         quiet = (ph == 0);
         run_mix(PHASE_ITEMS);
         settle();
      end
      quiet = 1'b0;

      // Longest timing, then flood the bit FIFO past full
      write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < FLOOD_PUSHES; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_item($urandom_range(0, 1) ? CMD_SEND : CMD_TICK, 1'b1, 1'b1);
         send_item(CMD_PUSH, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      end
      settle();

      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
